// ===== hw/rtl/iyrc_pkg.sv =====
package iyrc_pkg;

    localparam int CAL_SAMPLES    = 500;
    localparam int DETECT_SAMPLES = 200;
    localparam int NUM_AXES       = 3;
    localparam int NUM_REGS       = 4;
    localparam int ADDR_W         = $clog2(4 * NUM_REGS);
    localparam int COUNT_W        = 9;

    localparam logic [15:0] GAIN_RESET = 16'd6554;

    localparam logic [COUNT_W-1:0] CAL_COUNT    = COUNT_W'(CAL_SAMPLES);
    localparam logic [COUNT_W-1:0] DETECT_COUNT = COUNT_W'(DETECT_SAMPLES);

    // The bias is floor((sum*256 + CAL_SAMPLES/2) / CAL_SAMPLES). The quotient is
    // taken as (u * BIAS_RECIP) >> BIAS_SHIFT, which is exact for any u below 2^32.
    localparam int          BIAS_SHIFT = 32 + $clog2(CAL_SAMPLES);
    localparam logic [64:0] BIAS_ONE   = 65'(1) << BIAS_SHIFT;
    localparam logic [32:0] BIAS_RECIP =
        33'((BIAS_ONE + 65'(CAL_SAMPLES - 1)) / 65'(CAL_SAMPLES));
    localparam logic [8:0]  BIAS_HALF  = 9'(CAL_SAMPLES / 2);
    localparam logic [8:0]  BIAS_ROUND = 9'(CAL_SAMPLES - 1);

    typedef enum logic [1:0] {
        REG_ACCEL_GAIN   = 2'd0,
        REG_YAW_AXIS     = 2'd1,
        REG_YAW_NEGATIVE = 2'd2,
        REG_RUN_MODE     = 2'd3
    } t_reg_idx;

    localparam logic [1:0] MODE_NORMAL = 2'd0;
    localparam logic [1:0] MODE_CAL    = 2'd1;
    localparam logic [1:0] MODE_DETECT = 2'd2;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic signed [24:0] yaw_rate;
        logic signed [23:0] filt_accel_x;
        logic signed [23:0] filt_accel_y;
        logic signed [23:0] filt_accel_z;
        logic signed [23:0] bias_value;
        logic               calibration_done;
        logic               detect_done;
        logic [1:0]         detected_axis;
    } t_result;

    typedef struct packed {
        logic step;
        logic sum_en;
        logic sum_clr;
    } t_lane_ctl;

    function automatic logic signed [23:0] sat24(input logic signed [33:0] v);
        logic signed [33:0] hi;
        logic signed [33:0] lo;
        hi = 34'sd8388607;
        lo = -34'sd8388608;
        if (v > hi) begin
            return 24'sh7FFFFF;
        end else if (v < lo) begin
            return 24'sh800000;
        end
        return 24'(v);
    endfunction

    function automatic logic signed [24:0] sat25(input logic signed [25:0] v);
        logic signed [25:0] hi;
        logic signed [25:0] lo;
        hi = 26'sd16777215;
        lo = -26'sd16777216;
        if (v > hi) begin
            return 25'sh0FFFFFF;
        end else if (v < lo) begin
            return 25'sh1000000;
        end
        return 25'(v);
    endfunction

endpackage

// ===== hw/rtl/iyrc_lane.sv =====
module iyrc_lane (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iyrc_pkg::t_lane_ctl  i_ctl,
    input  logic signed [15:0]   i_sample,
    input  logic [15:0]          i_gain,
    output logic signed [23:0]   o_filt_next,
    output logic signed [23:0]   o_sum_next
);

    logic signed [23:0] r_filt;
    logic signed [23:0] r_sum;
    logic signed [23:0] n_filt;
    logic signed [23:0] n_sum;
    logic signed [24:0] w_delta;
    logic signed [41:0] w_prod;
    logic signed [25:0] w_step;

    always_comb begin
        w_delta = 25'($signed({i_sample, 8'd0})) - 25'(r_filt);
        w_prod  = 42'($signed({1'b0, i_gain})) * 42'(w_delta);
        // Round half up, then floor: arithmetic shift of the biased product.
        w_step  = 26'((w_prod + 42'sd32768) >>> 16);
        n_filt  = iyrc_pkg::sat24(34'(r_filt) + 34'(w_step));
        n_sum   = iyrc_pkg::sat24(34'(r_sum) + 34'(i_sample));
    end

    assign o_filt_next = n_filt;
    assign o_sum_next  = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filt <= '0;
            r_sum  <= '0;
        end else begin
            if (i_ctl.step) begin
                r_filt <= n_filt;
            end
            if (i_ctl.sum_clr) begin
                r_sum <= '0;
            end else if (i_ctl.sum_en) begin
                r_sum <= n_sum;
            end
        end
    end

endmodule

// ===== hw/rtl/iyrc_merge.sv =====
module iyrc_merge (
    input  logic signed [23:0] i_sum [iyrc_pkg::NUM_AXES],
    output logic [1:0]         o_axis
);

    logic [23:0] w_abs [iyrc_pkg::NUM_AXES];
    logic [23:0] w_best_abs;

    always_comb begin
        for (int i = 0; i < iyrc_pkg::NUM_AXES; i++) begin
            w_abs[i] = i_sum[i][23] ? 24'(-i_sum[i]) : 24'(i_sum[i]);
        end
        // Strict compares, so a tie keeps the lower axis.
        o_axis     = iyrc_pkg::AXIS_X;
        w_best_abs = w_abs[0];
        if (w_abs[1] > w_best_abs) begin
            o_axis     = iyrc_pkg::AXIS_Y;
            w_best_abs = w_abs[1];
        end
        if (w_abs[2] > w_best_abs) begin
            o_axis = iyrc_pkg::AXIS_Z;
        end
    end

endmodule

// ===== hw/rtl/iyrc_bias_div.sv =====
module iyrc_bias_div (
    input  logic               i_clk,
    input  logic               i_start,
    input  logic signed [24:0] i_sum,
    output logic signed [23:0] o_bias
);

    logic signed [33:0] w_num;
    logic [31:0]        n_u;
    logic [31:0]        r_u;
    logic               r_neg;
    logic [64:0]        r_prod;
    logic               r_neg_q;
    logic [32:0]        w_quot;
    logic signed [33:0] w_signed;

    // A negative numerator is floored as -ceil(|w| / n).
    always_comb begin
        w_num = 34'($signed({i_sum, 8'd0})) + 34'($signed({1'b0, iyrc_pkg::BIAS_HALF}));
        if (w_num[33]) begin
            n_u = 32'(34'(-w_num) + 34'(iyrc_pkg::BIAS_ROUND));
        end else begin
            n_u = 32'(w_num);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_u   <= n_u;
            r_neg <= w_num[33];
        end
        r_prod  <= 65'(r_u) * 65'(iyrc_pkg::BIAS_RECIP);
        r_neg_q <= r_neg;
    end

    always_comb begin
        w_quot   = 33'(r_prod >> iyrc_pkg::BIAS_SHIFT);
        w_signed = r_neg_q ? -$signed({1'b0, w_quot}) : $signed({1'b0, w_quot});
        o_bias   = iyrc_pkg::sat24(w_signed);
    end

endmodule

// ===== hw/rtl/iyrc_out_buf.sv =====
module iyrc_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  iyrc_pkg::t_result   i_data,
    input  logic                i_pop,
    output logic                o_valid,
    output logic                o_full,
    output iyrc_pkg::t_result   o_data
);

    iyrc_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic [1:0]        n_count;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/imu_yaw_rate_conditioner_top.sv =====
// Channel   Dir  Handshake                     Payload
// sample    in   i_in_valid / o_in_ready       i_accel_x/y/z, i_gyro_x/y/z
// result    out  o_out_valid / i_out_ready     o_yaw_rate, o_filt_accel_x/y/z, o_bias_value,
//                                              o_calibration_done, o_detect_done, o_detected_axis
// config    in   APB psel/penable/pwrite       paddr, pwdata, prdata, pready
//
// One sample per cycle while o_in_ready is high; its result is registered into the result buffer on acceptance.
// The sample that ends a calibration run goes through the bias reciprocal multiplier
// pipeline (operand load, multiply, saturate), which holds o_in_ready low meanwhile.
// A two-entry result buffer lets one more transaction in while a result is stalled.
// Synchronous active-low reset restores register defaults and clears filters,
// bias, sums and the sample count.
module imu_yaw_rate_conditioner_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic signed [15:0]            i_accel_x,
    input  logic signed [15:0]            i_accel_y,
    input  logic signed [15:0]            i_accel_z,
    input  logic signed [15:0]            i_gyro_x,
    input  logic signed [15:0]            i_gyro_y,
    input  logic signed [15:0]            i_gyro_z,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [24:0]            o_yaw_rate,
    output logic signed [23:0]            o_filt_accel_x,
    output logic signed [23:0]            o_filt_accel_y,
    output logic signed [23:0]            o_filt_accel_z,
    output logic signed [23:0]            o_bias_value,
    output logic                          o_calibration_done,
    output logic                          o_detect_done,
    output logic [1:0]                    o_detected_axis,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [iyrc_pkg::ADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_MUL  = 3'b010,
        S_FIN  = 3'b100
    } t_div_state;

    t_div_state r_state;
    logic [15:0]                     r_accel_gain;
    logic [1:0]                      r_yaw_axis;
    logic                            r_yaw_negative;
    logic [1:0]                      r_run_mode;
    logic [iyrc_pkg::COUNT_W-1:0]    r_count;
    logic signed [24:0]              r_cal_sum;
    logic signed [23:0]              r_bias;
    iyrc_pkg::t_result               r_pend;

    logic                            w_cfg_wr;
    iyrc_pkg::t_reg_idx              w_cfg_idx;
    logic                            w_mode_wr;
    logic                            w_accept;
    logic                            w_cal;
    logic                            w_det;
    logic [iyrc_pkg::COUNT_W-1:0]    n_count;
    logic                            w_cal_done;
    logic                            w_det_done;
    logic signed [15:0]              w_gyro_sel;
    logic signed [16:0]              w_yaw;
    logic signed [24:0]              w_rate;
    logic signed [24:0]              n_cal_sum;
    logic                            w_fin_push;
    logic                            w_push;
    logic                            w_buf_full;
    iyrc_pkg::t_result               w_result;
    iyrc_pkg::t_result               w_fin_result;
    iyrc_pkg::t_result               w_push_data;
    iyrc_pkg::t_result               w_out;
    iyrc_pkg::t_lane_ctl             w_lane_ctl;
    logic signed [15:0]              w_accel    [iyrc_pkg::NUM_AXES];
    logic signed [23:0]              w_filt_next[iyrc_pkg::NUM_AXES];
    logic signed [23:0]              w_sum_next [iyrc_pkg::NUM_AXES];
    logic [1:0]                      w_merge_axis;
    logic signed [23:0]              w_div_bias;

    // Configuration port.
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_cfg_idx = iyrc_pkg::t_reg_idx'(paddr[iyrc_pkg::ADDR_W-1:2]);
    assign w_mode_wr = w_cfg_wr && (w_cfg_idx == iyrc_pkg::REG_RUN_MODE);

    always_comb begin
        case (w_cfg_idx)
            iyrc_pkg::REG_ACCEL_GAIN:   prdata = 32'(r_accel_gain);
            iyrc_pkg::REG_YAW_AXIS:     prdata = 32'(r_yaw_axis);
            iyrc_pkg::REG_YAW_NEGATIVE: prdata = 32'(r_yaw_negative);
            iyrc_pkg::REG_RUN_MODE:     prdata = 32'(r_run_mode);
            default:                    prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_gain   <= iyrc_pkg::GAIN_RESET;
            r_yaw_axis     <= iyrc_pkg::AXIS_Z;
            r_yaw_negative <= 1'b0;
            r_run_mode     <= iyrc_pkg::MODE_NORMAL;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                iyrc_pkg::REG_ACCEL_GAIN: begin
                    r_accel_gain <= pwdata[15:0];
                end
                iyrc_pkg::REG_YAW_AXIS: begin
                    r_yaw_axis <= (pwdata[1:0] == 2'd3) ? iyrc_pkg::AXIS_Z : pwdata[1:0];
                end
                iyrc_pkg::REG_YAW_NEGATIVE: begin
                    r_yaw_negative <= pwdata[0];
                end
                iyrc_pkg::REG_RUN_MODE: begin
                    r_run_mode <= pwdata[1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Sample path.
    assign o_in_ready = (r_state == S_IDLE) && !w_buf_full;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_cal      = (r_run_mode == iyrc_pkg::MODE_CAL);
    assign w_det      = (r_run_mode == iyrc_pkg::MODE_DETECT);
    assign n_count    = r_count + iyrc_pkg::COUNT_W'(1);
    assign w_cal_done = w_cal && (n_count >= iyrc_pkg::CAL_COUNT);
    assign w_det_done = w_det && (n_count >= iyrc_pkg::DETECT_COUNT);

    always_comb begin
        case (r_yaw_axis)
            iyrc_pkg::AXIS_X: w_gyro_sel = i_gyro_x;
            iyrc_pkg::AXIS_Y: w_gyro_sel = i_gyro_y;
            default:          w_gyro_sel = i_gyro_z;
        endcase
        w_yaw     = r_yaw_negative ? -17'(w_gyro_sel) : 17'(w_gyro_sel);
        w_rate    = iyrc_pkg::sat25(26'($signed({w_yaw, 8'd0})) - 26'(r_bias));
        n_cal_sum = iyrc_pkg::sat25(26'(r_cal_sum) + 26'(w_yaw));
    end

    assign w_accel[0] = i_accel_x;
    assign w_accel[1] = i_accel_y;
    assign w_accel[2] = i_accel_z;

    always_comb begin
        w_lane_ctl.step    = w_accept;
        w_lane_ctl.sum_en  = w_accept && w_det;
        w_lane_ctl.sum_clr = w_mode_wr || (w_accept && (w_cal_done || w_det_done));
    end

    for (genvar g = 0; g < iyrc_pkg::NUM_AXES; g++) begin : g_lane
        iyrc_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_lane_ctl),
            .i_sample    (w_accel[g]),
            .i_gain      (r_accel_gain),
            .o_filt_next (w_filt_next[g]),
            .o_sum_next  (w_sum_next[g])
        );
    end

    iyrc_merge u_merge (
        .i_sum  (w_sum_next),
        .o_axis (w_merge_axis)
    );

    iyrc_bias_div u_bias_div (
        .i_clk   (i_clk),
        .i_start (w_accept && w_cal_done),
        .i_sum   (n_cal_sum),
        .o_bias  (w_div_bias)
    );

    always_comb begin
        w_result.yaw_rate         = w_rate;
        w_result.filt_accel_x     = w_filt_next[0];
        w_result.filt_accel_y     = w_filt_next[1];
        w_result.filt_accel_z     = w_filt_next[2];
        w_result.bias_value       = r_bias;
        w_result.calibration_done = w_cal_done;
        w_result.detect_done      = w_det_done;
        w_result.detected_axis    = w_det_done ? w_merge_axis : iyrc_pkg::AXIS_X;

        w_fin_result            = r_pend;
        w_fin_result.bias_value = w_div_bias;
    end

    // The completing calibration sample waits in r_pend until the new bias is out.
    assign w_fin_push  = (r_state == S_FIN) && !w_buf_full;
    assign w_push      = (w_accept && !w_cal_done) || w_fin_push;
    assign w_push_data = w_fin_push ? w_fin_result : w_result;

    always_ff @(posedge i_clk) begin
        if (w_accept && w_cal_done) begin
            r_pend <= w_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_cal_sum <= '0;
            r_bias    <= '0;
        end else begin
            if (w_mode_wr) begin
                r_count   <= '0;
                r_cal_sum <= '0;
            end else if (w_accept && (w_cal || w_det)) begin
                if (w_cal_done || w_det_done) begin
                    r_count   <= '0;
                    r_cal_sum <= '0;
                end else begin
                    r_count <= n_count;
                    if (w_cal) begin
                        r_cal_sum <= n_cal_sum;
                    end
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_cal_done) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (w_fin_push) begin
                        r_bias  <= w_div_bias;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    iyrc_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_data),
        .i_pop   (o_out_valid && i_out_ready),
        .o_valid (o_out_valid),
        .o_full  (w_buf_full),
        .o_data  (w_out)
    );

    assign o_yaw_rate         = w_out.yaw_rate;
    assign o_filt_accel_x     = w_out.filt_accel_x;
    assign o_filt_accel_y     = w_out.filt_accel_y;
    assign o_filt_accel_z     = w_out.filt_accel_z;
    assign o_bias_value       = w_out.bias_value;
    assign o_calibration_done = w_out.calibration_done;
    assign o_detect_done      = w_out.detect_done;
    assign o_detected_axis    = w_out.detected_axis;

`ifndef ASSERT_OFF
    a_cal_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_cal_done) |=> (r_state == S_MUL && r_count == '0 && r_cal_sum == '0))
        else $error("calibration completion did not start the bias pipeline");

    a_cal_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_mode == iyrc_pkg::MODE_CAL) |-> (r_count < iyrc_pkg::CAL_COUNT))
        else $error("calibration sample count ran past its limit");

    a_det_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_run_mode == iyrc_pkg::MODE_DETECT) |-> (r_count < iyrc_pkg::DETECT_COUNT))
        else $error("detection sample count ran past its limit");
`endif

endmodule

// ===== tb/imu_yaw_rate_conditioner_top_tb.sv =====
`timescale 1ns / 100ps

module imu_yaw_rate_conditioner_top_tb;

    typedef struct packed {
        logic [2:0][15:0] accel;
        logic [2:0][15:0] gyro;
    } t_imu_sample;

    localparam int     STALL_MAX      = 17;
    localparam int     WATCHDOG_LIMIT = 2000;
    localparam longint SAT24_HI       = 8388607;
    localparam longint SAT24_LO       = -8388608;
    localparam longint SAT25_HI       = 16777215;
    localparam longint SAT25_LO       = -16777216;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_in_valid  = 1'b0;
    logic                        o_in_ready;
    logic signed [15:0]          i_accel_x   = '0;
    logic signed [15:0]          i_accel_y   = '0;
    logic signed [15:0]          i_accel_z   = '0;
    logic signed [15:0]          i_gyro_x    = '0;
    logic signed [15:0]          i_gyro_y    = '0;
    logic signed [15:0]          i_gyro_z    = '0;
    logic                        o_out_valid;
    logic                        i_out_ready = 1'b0;
    logic signed [24:0]          o_yaw_rate;
    logic signed [23:0]          o_filt_accel_x;
    logic signed [23:0]          o_filt_accel_y;
    logic signed [23:0]          o_filt_accel_z;
    logic signed [23:0]          o_bias_value;
    logic                        o_calibration_done;
    logic                        o_detect_done;
    logic [1:0]                  o_detected_axis;
    logic                        psel        = 1'b0;
    logic                        penable     = 1'b0;
    logic                        pwrite      = 1'b0;
    logic [iyrc_pkg::ADDR_W-1:0] paddr       = '0;
    logic [31:0]                 pwdata      = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // Shadow copy of the registers and the conditioning state.
    int unsigned cfg_gain   = iyrc_pkg::GAIN_RESET;
    logic [1:0]  cfg_axis   = iyrc_pkg::AXIS_Z;
    logic        cfg_negate = 1'b0;
    logic [1:0]  cfg_mode   = iyrc_pkg::MODE_NORMAL;
    longint      filt_state [3] = '{default: 0};
    longint      bias_state = 0;
    longint      cal_total  = 0;
    longint      axis_total [3] = '{default: 0};
    int          sample_tally = 0;

    t_imu_sample       pending_samples [$];
    iyrc_pkg::t_result expected_results [$];
    t_imu_sample       tx_sample;
    t_imu_sample       seen_sample;
    iyrc_pkg::t_result want;

    int error_count      = 0;
    int samples_queued   = 0;
    int samples_sent     = 0;
    int results_checked  = 0;
    int cal_runs_done    = 0;
    int detect_runs_done = 0;
    int idle_cycles      = 0;
    int tx_wait          = 0;
    int rx_wait          = 0;
    bit tx_burst         = 1'b0;
    bit rx_burst         = 1'b0;

    imu_yaw_rate_conditioner_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_accel_x          (i_accel_x),
        .i_accel_y          (i_accel_y),
        .i_accel_z          (i_accel_z),
        .i_gyro_x           (i_gyro_x),
        .i_gyro_y           (i_gyro_y),
        .i_gyro_z           (i_gyro_z),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_yaw_rate         (o_yaw_rate),
        .o_filt_accel_x     (o_filt_accel_x),
        .o_filt_accel_y     (o_filt_accel_y),
        .o_filt_accel_z     (o_filt_accel_z),
        .o_bias_value       (o_bias_value),
        .o_calibration_done (o_calibration_done),
        .o_detect_done      (o_detect_done),
        .o_detected_axis    (o_detected_axis),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint saturate(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint floor_quotient(longint v, longint d);
        return (v >= 0) ? v / d : -((-v + d - 1) / d);
    endfunction

    function automatic void clear_accumulators();
        cal_total    = 0;
        axis_total   = '{default: 0};
        sample_tally = 0;
    endfunction

    function automatic void apply_cfg(iyrc_pkg::t_reg_idx idx, logic [31:0] data);
        case (idx)
            iyrc_pkg::REG_ACCEL_GAIN: begin
                cfg_gain = data[15:0];
            end
            iyrc_pkg::REG_YAW_AXIS: begin
                cfg_axis = (data[1:0] > iyrc_pkg::AXIS_Z) ? iyrc_pkg::AXIS_Z : data[1:0];
            end
            iyrc_pkg::REG_YAW_NEGATIVE: begin
                cfg_negate = data[0];
            end
            iyrc_pkg::REG_RUN_MODE: begin
                cfg_mode = data[1:0];
                clear_accumulators();
            end
            default: begin
            end
        endcase
    endfunction

    // Advances the shadow state by one sample and returns the result it should produce.
    function automatic iyrc_pkg::t_result condition_sample(t_imu_sample s);
        iyrc_pkg::t_result r;
        longint  raw [3];
        longint  yaw;
        longint  step;
        longint  mag;
        longint  mag_best;
        int      best;
        int      i;
        r = '0;
        for (i = 0; i < iyrc_pkg::NUM_AXES; i++) begin
            raw[i] = longint'($signed(s.accel[i]));
            step = (longint'(cfg_gain) * (raw[i] * 256 - filt_state[i]) + 32768) >>> 16;
            filt_state[i] = saturate(filt_state[i] + step, SAT24_LO, SAT24_HI);
        end
        yaw = longint'($signed(s.gyro[cfg_axis]));
        if (cfg_negate) begin
            yaw = -yaw;
        end
        r.yaw_rate = 25'(saturate(yaw * 256 - bias_state, SAT25_LO, SAT25_HI));
        if (cfg_mode == iyrc_pkg::MODE_CAL) begin
            cal_total = saturate(cal_total + yaw, SAT25_LO, SAT25_HI);
            sample_tally = (sample_tally + 1) % 512;
            if (sample_tally >= iyrc_pkg::CAL_SAMPLES) begin
                // Average scaled to Q.8 and rounded half up.
                bias_state = saturate(floor_quotient(cal_total * 512 + iyrc_pkg::CAL_SAMPLES,
                                                     2 * iyrc_pkg::CAL_SAMPLES),
                                      SAT24_LO, SAT24_HI);
                r.calibration_done = 1'b1;
                cal_runs_done++;
                clear_accumulators();
            end
        end else if (cfg_mode == iyrc_pkg::MODE_DETECT) begin
            for (i = 0; i < iyrc_pkg::NUM_AXES; i++) begin
                axis_total[i] = saturate(axis_total[i] + raw[i], SAT24_LO, SAT24_HI);
            end
            sample_tally = (sample_tally + 1) % 512;
            if (sample_tally >= iyrc_pkg::DETECT_SAMPLES) begin
                best = 0;
                mag_best = (axis_total[0] < 0) ? -axis_total[0] : axis_total[0];
                for (i = 1; i < iyrc_pkg::NUM_AXES; i++) begin
                    mag = (axis_total[i] < 0) ? -axis_total[i] : axis_total[i];
                    if (mag > mag_best) begin
                        best = i;
                        mag_best = mag;
                    end
                end
                r.detect_done = 1'b1;
                r.detected_axis = 2'(best);
                detect_runs_done++;
                clear_accumulators();
            end
        end
        r.filt_accel_x = 24'(filt_state[0]);
        r.filt_accel_y = 24'(filt_state[1]);
        r.filt_accel_z = 24'(filt_state[2]);
        r.bias_value   = 24'(bias_state);
        return r;
    endfunction

    function automatic logic [15:0] rand_word();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'($urandom_range(0, 255));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] near_value(int center, int spread);
        int v;
        v = center + int'($urandom_range(0, 2 * spread)) - spread;
        if (v > 32767) begin
            v = 32767;
        end
        if (v < -32768) begin
            v = -32768;
        end
        return 16'(v);
    endfunction

    function automatic t_imu_sample make_sample(logic [15:0] ax, logic [15:0] ay,
                                                logic [15:0] az, logic [15:0] gx,
                                                logic [15:0] gy, logic [15:0] gz);
        t_imu_sample s;
        s.accel[0] = ax;
        s.accel[1] = ay;
        s.accel[2] = az;
        s.gyro[0]  = gx;
        s.gyro[1]  = gy;
        s.gyro[2]  = gz;
        return s;
    endfunction

    function automatic t_imu_sample noise_sample();
        return make_sample(rand_word(), rand_word(), rand_word(),
                           rand_word(), rand_word(), rand_word());
    endfunction

    // One axis carries gravity with the given sign, the others stay near zero.
    function automatic t_imu_sample tilt_sample(int up_axis, bit flip);
        t_imu_sample s;
        int          i;
        s = noise_sample();
        for (i = 0; i < iyrc_pkg::NUM_AXES; i++) begin
            s.accel[i] = near_value(0, 6000);
        end
        s.accel[up_axis] = near_value(flip ? -24000 : 24000, 8000);
        return s;
    endfunction

    // Two axes see equal and opposite values so their sums tie in magnitude.
    function automatic t_imu_sample level_sample(int a, int b);
        t_imu_sample s;
        int          v;
        s = noise_sample();
        v = $urandom_range(1000, 32767);
        s.accel[a] = 16'(v);
        s.accel[b] = 16'(-v);
        s.accel[3 - a - b] = near_value(0, 50);
        return s;
    endfunction

    function automatic void queue_sample(t_imu_sample s);
        pending_samples.push_back(s);
        samples_queued++;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(input string field, input logic [24:0] got,
                               input logic [24:0] exp_val);
        if (got !== exp_val) begin
            flag_error($sformatf("%s of result %0d is %h, expected %h",
                                 field, results_checked, got, exp_val));
        end
    endtask

    task automatic cfg_write(input iyrc_pkg::t_reg_idx idx, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        apply_cfg(idx, data);
    endtask

    // Holds the sender back until every queued sample has been accepted and answered.
    task automatic wait_for_quiet();
        do @(posedge i_clk);
        while (samples_sent != samples_queued || expected_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                seen_sample = make_sample(i_accel_x, i_accel_y, i_accel_z,
                                          i_gyro_x, i_gyro_y, i_gyro_z);
                expected_results.push_back(condition_sample(seen_sample));
                samples_sent++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_in_valid <= 1'b0;
                end else if (pending_samples.size() != 0) begin
                    tx_sample = pending_samples.pop_front();
                    i_accel_x  <= tx_sample.accel[0];
                    i_accel_y  <= tx_sample.accel[1];
                    i_accel_z  <= tx_sample.accel[2];
                    i_gyro_x   <= tx_sample.gyro[0];
                    i_gyro_y   <= tx_sample.gyro[1];
                    i_gyro_z   <= tx_sample.gyro[2];
                    i_in_valid <= 1'b1;
                    if ($urandom_range(0, 47) == 0) begin
                        tx_burst = !tx_burst;
                    end
                    tx_wait = tx_burst ? 0 : $urandom_range(0, STALL_MAX);
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    flag_error("result transaction with no sample outstanding");
                end else begin
                    want = expected_results.pop_front();
                    check_field("yaw_rate", o_yaw_rate, want.yaw_rate);
                    check_field("filt_accel_x", o_filt_accel_x, want.filt_accel_x);
                    check_field("filt_accel_y", o_filt_accel_y, want.filt_accel_y);
                    check_field("filt_accel_z", o_filt_accel_z, want.filt_accel_z);
                    check_field("bias_value", o_bias_value, want.bias_value);
                    check_field("calibration_done", o_calibration_done,
                                want.calibration_done);
                    check_field("detect_done", o_detect_done, want.detect_done);
                    check_field("detected_axis", o_detected_axis, want.detected_axis);
                end
                results_checked++;
                if ($urandom_range(0, 47) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_wait = rx_burst ? 0 : $urandom_range(0, STALL_MAX);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_imu_sample s;
        int          ax;
        int          dom;
        int          pair;
        int          center;
        int          spread;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Field extremes at the reset settings.
        queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
        queue_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        queue_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000));
        queue_sample(make_sample(16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000));

        // Full gain, x axis negated: the most negative rate becomes positive.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, 32'hFFFF_FFFF);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, iyrc_pkg::AXIS_X);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, 32'h0000_0001);
        queue_sample(make_sample(16'h8000, 16'h7FFF, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        queue_sample(make_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h0001));
        queue_sample(make_sample(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h8000));

        // Zero gain freezes the filter.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, 32'h0000_0000);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, iyrc_pkg::AXIS_Y);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, 32'h0000_0000);
        queue_sample(make_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF));
        queue_sample(make_sample(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000));

        // An axis code above z must clamp to z.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, 32'h0000_0001);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, 32'd3);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, 32'hFFFF_FFFF);
        queue_sample(make_sample(16'h0001, 16'h0002, 16'h0003, 16'h7FFF, 16'h8000, 16'h8000));
        queue_sample(make_sample(16'hFFFF, 16'hFFFE, 16'hFFFD, 16'h8000, 16'h7FFF, 16'h7FFF));

        // The unused mode code must filter like normal mode and accumulate nothing.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, 32'h0000_8000);
        cfg_write(iyrc_pkg::REG_RUN_MODE, 32'd3);
        repeat (3) queue_sample(noise_sample());

        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_NORMAL);
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, $urandom);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, $urandom);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, $urandom);
        repeat (30) queue_sample(noise_sample());

        // Calibrate on a pinned negative rate so the bias lands on its lower limit.
        wait_for_quiet();
        ax = $urandom_range(0, 2);
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, $urandom);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, ax);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, 32'h0000_0000);
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_CAL);
        repeat (iyrc_pkg::CAL_SAMPLES) begin
            s = noise_sample();
            s.gyro[ax] = 16'h8000;
            queue_sample(s);
        end

        // With that bias, a negated full-scale rate drives yaw_rate into saturation.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_NORMAL);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, 32'h0000_0001);
        repeat (20) begin
            s = noise_sample();
            if ($urandom_range(0, 1) == 1) begin
                s.gyro[ax] = 16'h8000;
            end
            queue_sample(s);
        end

        // A detection cut short by a mode write, then two runs back to back.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, $urandom);
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_DETECT);
        dom = $urandom_range(0, 2);
        repeat (20) queue_sample(tilt_sample(dom, 1'b1));
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_DETECT);
        repeat (2) begin
            dom = $urandom_range(0, 2);
            s = '0;
            repeat (iyrc_pkg::DETECT_SAMPLES) begin
                if ($urandom_range(0, 9) == 0) begin
                    queue_sample(noise_sample());
                end else begin
                    queue_sample(tilt_sample(dom, $urandom_range(0, 1)));
                end
            end
        end

        // Equal magnitudes on two axes: the lower index must win.
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_DETECT);
        pair = $urandom_range(0, 2);
        repeat (iyrc_pkg::DETECT_SAMPLES) begin
            case (pair)
                0: queue_sample(level_sample(0, 1));
                1: queue_sample(level_sample(2, 0));
                default: queue_sample(level_sample(1, 2));
            endcase
        end

        // Calibration around a random rate after an aborted start.
        wait_for_quiet();
        ax = $urandom_range(0, 2);
        center = int'($urandom_range(0, 65535)) - 32768;
        spread = $urandom_range(0, 3000);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, ax);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, $urandom);
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_CAL);
        repeat (20) queue_sample(noise_sample());
        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_CAL);
        repeat (iyrc_pkg::CAL_SAMPLES) begin
            s = noise_sample();
            s.gyro[ax] = near_value(center, spread);
            queue_sample(s);
        end

        wait_for_quiet();
        cfg_write(iyrc_pkg::REG_RUN_MODE, iyrc_pkg::MODE_NORMAL);
        cfg_write(iyrc_pkg::REG_ACCEL_GAIN, $urandom);
        cfg_write(iyrc_pkg::REG_YAW_AXIS, $urandom);
        cfg_write(iyrc_pkg::REG_YAW_NEGATIVE, $urandom);
        repeat (30) queue_sample(noise_sample());

        wait_for_quiet();
        repeat (8) @(posedge i_clk);
        $display("Summary: %0d samples and %0d results over normal, unused, calibrate and %s",
                 samples_sent, results_checked, "detect modes");
        $display("Summary: %0d bias calibrations, %0d axis detections, %0d mismatches",
                 cal_runs_done, detect_runs_done, error_count);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
